/* rtl/rltm_pkg.sv */
package rltm_pkg;

	localparam int CfgIdxBits = 1;
	localparam int CfgDataBits = 17;
	localparam logic [CfgIdxBits-1:0] REG_WHITE = 1'd0;
	localparam logic [CfgIdxBits-1:0] REG_THRESH = 1'd1;

	typedef enum logic [1:0] {
		ACT_APPEND_A = 2'd0,
		ACT_APPEND_B = 2'd1,
		ACT_COMPARE  = 2'd2,
		ACT_NONE     = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [23:0] change_time;
		logic [7:0]  color;
		logic [23:0] length_a;
		logic [23:0] length_b;
	} in_word_t;

	typedef struct packed {
		logic [23:0] mismatch_time;
		logic [16:0] score;
		logic        is_neighbour;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_WAIT,
		ST_STEP,
		ST_DIV,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch compare word, reset walk
		logic fetch;     // issue memory reads for current indices
		logic step;      // advance walk one change
		logic div_start;
		logic div_run;
		logic finish;    // present result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic walk_done;
		logic div_done;
	} sts_t;

endpackage

/* rtl/rltm_ctrl.sv */
module rltm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  rltm_pkg::sts_t sts,
	output rltm_pkg::cmd_t cmd,
	output logic          busy
);
	import rltm_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (go) begin
					cmd.load = 1'b1;
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: state_d = ST_STEP;
			ST_STEP: begin
				if (sts.walk_done) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end else begin
					cmd.step = 1'b1;
					state_d = ST_FETCH;
				end
			end
			ST_DIV: begin
				cmd.div_run = 1'b1;
				if (sts.div_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* rtl/rltm_dp.sv */
module rltm_dp #(
	parameter int MAX_CHANGES = 1024,
	parameter int TIME_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  rltm_pkg::in_word_t in_word,
	input  logic [7:0]         white_q,
	input  logic [16:0]        thresh_q,
	input  rltm_pkg::cmd_t     cmd,
	output rltm_pkg::sts_t     sts,
	output logic               result_valid,
	output rltm_pkg::out_word_t result
);
	import rltm_pkg::*;

	localparam int AW = $clog2(MAX_CHANGES);
	localparam int CW = $clog2(MAX_CHANGES + 1);
	localparam int EW = TIME_BITS + 8;
	localparam int DIVW = TIME_BITS + 16;
	localparam int DCW = $clog2(DIVW + 1);
	localparam logic [TIME_BITS-1:0] TMAX = '1;

	logic [EW-1:0] mem_a [MAX_CHANGES];
	logic [EW-1:0] mem_b [MAX_CHANGES];
	logic [CW-1:0] count_a_q, count_b_q;
	logic [CW-1:0] ia_q, ib_q;
	logic [EW-1:0] a_cur_q, a_nxt_q, b_cur_q, b_nxt_q;
	logic [TIME_BITS-1:0] t_q, acc_q;
	logic [23:0] longest_q;
	logic [DIVW-1:0] quo_q;
	logic [24:0] rem_q;
	logic [DCW-1:0] dcnt_q;
	logic result_valid_q;
	out_word_t result_q;

	logic [TIME_BITS-1:0] wtime;
	assign wtime = TIME_BITS >= 24 ? TIME_BITS'(in_word.change_time)
		: in_word.change_time[TIME_BITS-1:0];

	logic wr_a, wr_b;
	assign wr_a = accept && in_word.action == ACT_APPEND_A && count_a_q < CW'(MAX_CHANGES);
	assign wr_b = accept && in_word.action == ACT_APPEND_B && count_b_q < CW'(MAX_CHANGES);

	always_ff @(posedge clk) begin
		if (wr_a) mem_a[count_a_q[AW-1:0]] <= {wtime, in_word.color};
		if (wr_b) mem_b[count_b_q[AW-1:0]] <= {wtime, in_word.color};
	end

	// two reads per store through two ports, indices truncated to the address width
	logic [CW-1:0] ia1, ib1;
	assign ia1 = ia_q + 1'b1;
	assign ib1 = ib_q + 1'b1;
	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			a_cur_q <= mem_a[ia_q[AW-1:0]];
			a_nxt_q <= mem_a[ia1[AW-1:0]];
			b_cur_q <= mem_b[ib_q[AW-1:0]];
			b_nxt_q <= mem_b[ib1[AW-1:0]];
		end
	end

	logic more_a, more_b, in_a, in_b;
	logic [TIME_BITS-1:0] na, nb, tgt;
	logic [7:0] ca, cb;
	logic take_a, diff;
	logic [TIME_BITS:0] sum;
	assign in_a = ia_q < count_a_q;
	assign in_b = ib_q < count_b_q;
	assign more_a = ia1 < count_a_q;
	assign more_b = ib1 < count_b_q;
	assign na = a_nxt_q[EW-1:8];
	assign nb = b_nxt_q[EW-1:8];
	assign ca = a_cur_q[7:0];
	assign cb = b_cur_q[7:0];
	assign sts.walk_done = !(in_a && in_b) || !(more_a || more_b);

	always_comb begin
		take_a = more_a && (!more_b || na <= nb);
		tgt = take_a ? na : nb;
		if (more_a && more_b) diff = ca != cb;
		else if (more_a) diff = ca != white_q;
		else diff = cb != white_q;
		sum = {1'b0, acc_q} + {1'b0, tgt - t_q};
	end

	// restoring divider: (acc << 16) / longest
	logic [25:0] trial;
	assign trial = {rem_q, quo_q[DIVW-1]} - {2'b0, longest_q};
	assign sts.div_done = dcnt_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q <= '0;
			count_b_q <= '0;
			result_valid_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			result_valid_q <= cmd.finish;
			if (wr_a) count_a_q <= count_a_q + 1'b1;
			if (wr_b) count_b_q <= count_b_q + 1'b1;
			if (cmd.finish) count_b_q <= '0;
			if (cmd.div_start) dcnt_q <= DCW'(DIVW);
			else if (cmd.div_run && dcnt_q != '0) dcnt_q <= dcnt_q - 1'b1;
		end
	end

	logic [DIVW:0] sc_full;
	logic [16:0] score;
	logic [23:0] acc24;
	always_comb begin
		sc_full = {1'b0, quo_q};
		if (longest_q == '0) score = '0;
		else if (sc_full > (DIVW+1)'(65536)) score = 17'h10000;
		else score = sc_full[16:0];
		acc24 = TIME_BITS >= 24 ? acc_q[23:0] : 24'(acc_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ia_q <= '0;
			ib_q <= '0;
			t_q <= '0;
			acc_q <= '0;
			longest_q <= in_word.length_a > in_word.length_b ? in_word.length_a
				: in_word.length_b;
		end
		if (cmd.step) begin
			if (diff && tgt > t_q) acc_q <= sum[TIME_BITS] ? TMAX : sum[TIME_BITS-1:0];
			t_q <= tgt;
			if (take_a) ia_q <= ia1;
			else ib_q <= ib1;
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= {acc_q, 16'b0};
		end else if (cmd.div_run && dcnt_q != '0) begin
			if (!trial[25]) begin
				rem_q <= trial[24:0];
				quo_q <= {quo_q[DIVW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[23:0], quo_q[DIVW-1]};
				quo_q <= {quo_q[DIVW-2:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			result_q.mismatch_time <= acc24;
			result_q.score <= score;
			result_q.is_neighbour <= score < thresh_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

/* rtl/run_length_track_mismatch.sv */
// Run-length track mismatch scorer.
// Command channel: start with cmd word; accepted when start high and busy low.
// Action append A / append B store one entry per cycle while busy is low (an append leaves busy low).
// Action compare raises busy, walks both tracks one change at a time (memory
// read, registered data, accumulate), then a restoring divider holds busy
// while it makes one quotient bit a cycle, then a final check, for the Q1.16
// score. Result appears on result with done high for exactly one
// cycle; the receiver cannot stall it.
// A compare walks at most count_a+count_b-2 changes, then runs the bit-serial
// divider. busy is low again in the cycle done is high.
// Track B is emptied after each compare; track A stays loaded.
// Config: cfg_we, cfg_idx, cfg_data; index 0 white colour, 1 score threshold.
// Reset (arst_n low) clears counts, config to defaults, controller to idle;
// stored entries are not cleared and need no clearing pass.
module run_length_track_mismatch #(
	parameter int MAX_CHANGES = 1024,
	parameter int TIME_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  rltm_pkg::in_word_t   cmd_word,
	output logic                 busy,
	output logic                 done,
	output rltm_pkg::out_word_t  result,
	input  logic                 cfg_we,
	input  logic [rltm_pkg::CfgIdxBits-1:0]  cfg_idx,
	input  logic [rltm_pkg::CfgDataBits-1:0] cfg_data
);
	import rltm_pkg::*;

	logic [7:0] white_q;
	logic [16:0] thresh_q;
	logic accept, go;
	cmd_t cmd;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_q <= '0;
			thresh_q <= 17'd655;
		end else if (cfg_we) begin
			if (cfg_idx == REG_WHITE) white_q <= cfg_data[7:0];
			if (cfg_idx == REG_THRESH) thresh_q <= cfg_data;
		end
	end

	assign accept = start && !busy;
	assign go = start && cmd_word.action == ACT_COMPARE;

	rltm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .go(go), .sts(sts), .cmd(cmd), .busy(busy)
	);

	rltm_dp #(.MAX_CHANGES(MAX_CHANGES), .TIME_BITS(TIME_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .accept(accept), .in_word(cmd_word),
		.white_q(white_q), .thresh_q(thresh_q), .cmd(cmd), .sts(sts),
		.result_valid(done), .result(result)
	);

endmodule
